>>> hw/rtl/bsp_pkg.sv
`timescale 1ns / 1ps

package bsp_pkg;

  // Field widths of one request and one result
  localparam int unsigned OpcodeW  = 2;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned CountW   = 8;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned FlushedW = 3;

  // Saturation limits for field and run pushes
  localparam int unsigned MaxFieldBits = 32;
  localparam int unsigned MaxRunBits   = 255;

  // Opcodes
  localparam logic [OpcodeW-1:0] OpPushField = 2'd0;
  localparam logic [OpcodeW-1:0] OpPushRun   = 2'd1;
  localparam logic [OpcodeW-1:0] OpFlush     = 2'd2;

  typedef struct packed {
    logic [OpcodeW-1:0] opcode;
    logic [ValueW-1:0]  value;
    logic [CountW-1:0]  bit_count;
  } in_req_t;

  typedef struct packed {
    logic [ByteW-1:0]    out_byte;
    logic                byte_valid;
    logic [FlushedW-1:0] flushed_bits;
    logic                last;
  } out_rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic step;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic done;
  } dp_status_t;

endpackage

>>> hw/rtl/bsp_in_if.sv
`timescale 1ns / 1ps

interface bsp_in_if;
  import bsp_pkg::*;

  logic    valid;
  logic    ready;
  in_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/bsp_out_if.sv
`timescale 1ns / 1ps

interface bsp_out_if;
  import bsp_pkg::*;

  logic     valid;
  logic     ready;
  out_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/bsp_ctrl.sv
`timescale 1ns / 1ps

module bsp_ctrl
  import bsp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [OpcodeW-1:0]  in_opcode_i,
  output logic                in_ready_o,
  input  dp_status_t          status_i,
  output dp_cmd_t             cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic state_q, state_d;
  logic op_known;

  assign op_known = (in_opcode_i == OpPushField) || (in_opcode_i == OpPushRun) ||
                    (in_opcode_i == OpFlush);

  // Next state and datapath commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        // unused opcode is taken and dropped
        if (in_valid_i && op_known) begin
          cmd_o.load = 1'b1;
          state_d    = StRun;
        end
      end
      StRun: begin
        if (status_i.out_free) begin
          cmd_o.step = 1'b1;
          if (status_i.done) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hw/rtl/bsp_datapath.sv
`timescale 1ns / 1ps

module bsp_datapath
  import bsp_pkg::*;
#(
  parameter int unsigned MAX_FIELD_BITS = MaxFieldBits,
  parameter int unsigned MAX_RUN_BITS   = MaxRunBits
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_req_t    in_data_i,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_rsp_t   out_data_o
);

  // Bit source width, remaining-count width, shift-amount width
  localparam int unsigned DW     = (MAX_FIELD_BITS > ValueW) ? MAX_FIELD_BITS : ValueW;
  localparam int unsigned MaxCnt = (MAX_FIELD_BITS > MAX_RUN_BITS) ? MAX_FIELD_BITS
                                                                   : MAX_RUN_BITS;
  localparam int unsigned CW     = $clog2(MaxCnt + 1);
  localparam int unsigned SHW    = $clog2(DW + 1);

  logic [DW-1:0]      src_q, src_d;
  logic [CW-1:0]      rem_q, rem_d;
  logic [OpcodeW-1:0] mode_q, mode_d;
  logic               run_bit_q, run_bit_d;
  logic [ByteW-1:0]   partial_q, partial_d;
  logic [2:0]         fill_q, fill_d;
  logic               out_valid_q, out_valid_d;
  out_rsp_t           out_data_q, out_data_d;

  logic [DW-1:0]      val_ext, val_rev;
  logic [CW-1:0]      k_field, k_run;
  logic [3:0]         room, take;
  logic [CW-1:0]      rem_next;
  logic [ByteW:0]     mask9;
  logic [ByteW-1:0]   chunk, merged;
  logic [3:0]         fill_sum;
  logic               byte_done, out_free;

  // Reverse the value so that the first pushed bit sits at bit 0
  always_comb begin
    val_ext = DW'(in_data_i.value);
    for (int i = 0; i < DW; i++) begin
      val_rev[i] = val_ext[DW-1-i];
    end
  end

  // Saturated counts
  assign k_field = (32'(in_data_i.bit_count) > MAX_FIELD_BITS) ? CW'(MAX_FIELD_BITS)
                                                               : CW'(in_data_i.bit_count);
  assign k_run   = (32'(in_data_i.bit_count) > MAX_RUN_BITS) ? CW'(MAX_RUN_BITS)
                                                             : CW'(in_data_i.bit_count);

  // One byte-slot per step: take as many bits as fit in the partial byte
  assign room     = 4'd8 - {1'b0, fill_q};
  assign take     = (32'(rem_q) < 32'(room)) ? 4'(rem_q) : room;
  assign rem_next = rem_q - CW'(take);
  assign mask9    = (9'd1 << take) - 9'd1;
  assign chunk    = (mode_q == OpPushRun) ? {ByteW{run_bit_q}} : src_q[ByteW-1:0];
  assign merged   = partial_q | ((chunk & mask9[ByteW-1:0]) << fill_q);
  assign fill_sum = {1'b0, fill_q} + take;
  assign byte_done = fill_sum[3];

  assign out_free = !out_valid_q || out_ready_i;

  assign status_o.out_free = out_free;
  assign status_o.done     = (mode_q == OpFlush) || (rem_next == '0);

  // Load on accept, advance one step at a time
  always_comb begin
    src_d       = src_q;
    rem_d       = rem_q;
    mode_d      = mode_q;
    run_bit_d   = run_bit_q;
    partial_d   = partial_q;
    fill_d      = fill_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;

    if (cmd_i.load) begin
      mode_d    = in_data_i.opcode;
      run_bit_d = (in_data_i.value != '0);
      src_d     = val_rev >> (SHW'(DW) - SHW'(k_field));
      rem_d     = (in_data_i.opcode == OpPushRun) ? k_run : k_field;
    end else if (cmd_i.step) begin
      if (mode_q == OpFlush) begin
        out_valid_d             = 1'b1;
        out_data_d.out_byte     = partial_q;
        out_data_d.byte_valid   = (fill_q != '0);
        out_data_d.flushed_bits = fill_q;
        out_data_d.last         = 1'b1;
        partial_d               = '0;
        fill_d                  = '0;
      end else begin
        src_d = src_q >> take;
        rem_d = rem_next;
        if (byte_done) begin
          out_valid_d             = 1'b1;
          out_data_d.out_byte     = merged;
          out_data_d.byte_valid   = 1'b1;
          out_data_d.flushed_bits = '0;
          // no further byte can complete from what is left
          out_data_d.last         = (32'(rem_next) < 32'd8);
          partial_d               = '0;
          fill_d                  = '0;
        end else begin
          partial_d = merged;
          fill_d    = fill_sum[2:0];
        end
      end
    end
  end

  // Control and packing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      mode_q      <= OpPushField;
      partial_q   <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      mode_q      <= mode_d;
      partial_q   <= partial_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    src_q      <= src_d;
    run_bit_q  <= run_bit_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> hw/rtl/bit_stream_packer_core.sv
`timescale 1ns / 1ps

// Channel | Dir | Payload                                       | Request moves
// in_i    | in  | opcode, value, bit_count                      | one push or flush
// out_o   | out | out_byte, byte_valid, flushed_bits, last      | one byte result
//
// A request is taken while the sequencer is idle, then worked in steps of one byte slot per
// cycle: a step fills the partial byte from the bit source. A push (after saturation)
// is stepped until its bits are used up, a flush emits the partial byte, an unused
// opcode is taken and dropped; the next request is taken on the cycle after the last step.
// Steps stall while the output register holds a result not yet taken.
// Reset clears the partial byte, its fill count and the output valid.

module bit_stream_packer_core
  import bsp_pkg::*;
#(
  parameter int unsigned MAX_FIELD_BITS = MaxFieldBits,
  parameter int unsigned MAX_RUN_BITS   = MaxRunBits
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  bsp_in_if.sink          in_i,
  bsp_out_if.source       out_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer
  bsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_opcode_i (in_i.data.opcode),
    .in_ready_o  (in_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Bit source, packing state and output register
  bsp_datapath #(
    .MAX_FIELD_BITS (MAX_FIELD_BITS),
    .MAX_RUN_BITS   (MAX_RUN_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_i.data),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

endmodule
